// ===== design/modbus_rtu_frame_decoder_unit_assert.svh =====
// Assertion macros for the Modbus RTU frame decoder.
`ifndef MODBUS_RTU_FRAME_DECODER_UNIT_ASSERT_SVH
`define MODBUS_RTU_FRAME_DECODER_UNIT_ASSERT_SVH

// Same-cycle implication, quiet while reset is low.
`define MRFD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, quiet while reset is low.
`define MRFD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/mbrtu_pkg.sv =====
// Types and constants of the Modbus RTU frame decoder.
`default_nettype none

package mbrtu_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HDR,
        ST_PAY_RD,
        ST_PAY_WR
    } t_state;

    localparam logic [2:0] ERR_OK        = 3'd0;
    localparam logic [2:0] ERR_TOO_SHORT = 3'd1;
    localparam logic [2:0] ERR_BAD_CRC   = 3'd2;
    localparam logic [2:0] ERR_BAD_FUNC  = 3'd3;
    localparam logic [2:0] ERR_TOO_LONG  = 3'd4;

    localparam logic [7:0] FC_READ_FIRST      = 8'd1;
    localparam logic [7:0] FC_READ_LAST       = 8'd4;
    localparam logic [7:0] FC_WRITE_COIL      = 8'd5;
    localparam logic [7:0] FC_WRITE_REG       = 8'd6;
    localparam logic [7:0] FC_WRITE_COILS     = 8'd15;
    localparam logic [7:0] FC_WRITE_REGS      = 8'd16;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam int MIN_FRAME_LEN  = 5;
    localparam int REQ_FRAME_LEN  = 8;
    localparam int HDR_BYTES      = 7;

    localparam logic [2:0] PSTART_READ   = 3'd3;
    localparam logic [2:0] PSTART_SINGLE = 3'd4;
    localparam logic [2:0] PSTART_MULTI  = 3'd7;
    localparam logic [7:0] SINGLE_LEN    = 8'd2;

    // Fold one byte into a reflected CRC-16, one bit per step.
    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'd0, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== design/modbus_rtu_frame_decoder_unit.sv =====
// A word without frame end is absorbed into the frame store and the CRC.
// A word with frame end moves to the header state, which loads the header result
// once the output is free; then each payload result takes a frame-store read and a load.
// Throughput: one word per cycle while a frame arrives; frame end blocks input
// until the last result is loaded. Reset clears control, CRC and counts;
// the frame store is not cleared and needs no clearing pass.
`default_nettype none
`include "modbus_rtu_frame_decoder_unit_assert.svh"

module modbus_rtu_frame_decoder_unit #(
    parameter int FRAME_BYTES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_frame_end,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_kind,
    output logic [2:0]  o_error_code,
    output logic [7:0]  o_unit_id,
    output logic [7:0]  o_func_code,
    output logic [15:0] o_start_addr,
    output logic [15:0] o_quantity,
    output logic [7:0]  o_count_byte,
    output logic [7:0]  o_payload_len,
    output logic [15:0] o_received_crc,
    output logic [15:0] o_computed_crc,
    output logic [7:0]  o_payload_byte,
    output logic        o_last
);
    import mbrtu_pkg::*;

    localparam int AW = $clog2(FRAME_BYTES);
    localparam int CW = $clog2(FRAME_BYTES + 1);

    t_state          r_state, n_state;
    logic [CW-1:0]   r_count;
    logic            r_ovf;
    logic [15:0]     r_crc;
    logic [7:0]      r_prev1, r_prev2;
    logic [7:0]      r_hb [0:HDR_BYTES-1];
    logic [7:0]      r_mem [0:FRAME_BYTES-1];
    logic [7:0]      r_rd_data;
    logic [2:0]      r_pstart;
    logic [CW-1:0]   r_n, r_idx;

    logic            r_o_valid, r_o_kind, r_o_last;
    logic [2:0]      r_o_err;
    logic [7:0]      r_o_unit, r_o_func, r_o_cnt, r_o_plen, r_o_pbyte;
    logic [15:0]     r_o_start, r_o_qty, r_o_rcrc, r_o_ccrc;

    logic            w_in_acc, w_store, w_out_free;
    logic            w_load_hdr, w_load_pay, w_rd_en;
    logic [AW-1:0]   w_rd_addr;
    logic            w_idx_last;

    logic [2:0]      w_err;
    logic [7:0]      w_unit, w_func, w_cnt, w_plen, w_decl;
    logic [15:0]     w_start, w_qty, w_rcrc, w_ccrc;
    logic            w_has;
    logic [2:0]      w_pstart;
    logic [CW-1:0]   w_dlen, w_avail, w_n;
    logic [7:0]      w_gb [0:HDR_BYTES-1];

    assign o_in_stall = (r_state != ST_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_store    = w_in_acc && (r_count < CW'(FRAME_BYTES));
    assign w_out_free = !r_o_valid || !i_out_stall;
    assign w_rd_addr  = AW'(CW'(r_pstart) + r_idx);
    assign w_idx_last = (CW'(r_idx + CW'(1)) == r_n);

    // Header decode from the registered frame summary.
    always_comb begin
        w_err    = ERR_OK;
        w_start  = 16'd0;
        w_qty    = 16'd0;
        w_cnt    = 8'd0;
        w_decl   = 8'd0;
        w_rcrc   = 16'd0;
        w_ccrc   = 16'd0;
        w_has    = 1'b0;
        w_pstart = 3'd0;
        w_unit   = (r_count > CW'(0)) ? r_hb[0] : 8'd0;
        w_func   = (r_count > CW'(1)) ? r_hb[1] : 8'd0;
        w_dlen   = CW'(r_count - CW'(2));
        for (int k = 0; k < HDR_BYTES; k++) begin
            w_gb[k] = (CW'(k) < w_dlen) ? r_hb[k] : 8'd0;
        end
        if (r_ovf) begin
            w_err = ERR_TOO_LONG;
        end else if (r_count < CW'(MIN_FRAME_LEN)) begin
            w_err = ERR_TOO_SHORT;
        end else begin
            w_rcrc = {r_prev1, r_prev2};
            w_ccrc = r_crc;
            if (w_rcrc != w_ccrc) begin
                w_err = ERR_BAD_CRC;
            end else begin
                case (w_func) inside
                    [FC_READ_FIRST:FC_READ_LAST]: begin
                        if (r_count == CW'(REQ_FRAME_LEN)) begin
                            w_start = {w_gb[2], w_gb[3]};
                            w_qty   = {w_gb[4], w_gb[5]};
                        end else begin
                            w_cnt    = w_gb[2];
                            w_decl   = w_gb[2];
                            w_pstart = PSTART_READ;
                            w_has    = 1'b1;
                        end
                    end
                    FC_WRITE_COIL, FC_WRITE_REG: begin
                        w_start  = {w_gb[2], w_gb[3]};
                        w_decl   = SINGLE_LEN;
                        w_pstart = PSTART_SINGLE;
                        w_has    = 1'b1;
                    end
                    FC_WRITE_COILS, FC_WRITE_REGS: begin
                        w_start  = {w_gb[2], w_gb[3]};
                        w_qty    = {w_gb[4], w_gb[5]};
                        w_cnt    = w_gb[6];
                        w_decl   = w_gb[6];
                        w_pstart = PSTART_MULTI;
                        w_has    = 1'b1;
                    end
                    default: begin
                        w_err = ERR_BAD_FUNC;
                    end
                endcase
            end
        end
        // Clip payload to the bytes before the CRC.
        if (w_dlen > CW'(w_pstart)) begin
            w_avail = CW'(w_dlen - CW'(w_pstart));
        end else begin
            w_avail = CW'(0);
        end
        if (!w_has) begin
            w_n = CW'(0);
        end else if (w_decl < 8'(w_avail)) begin
            w_n = CW'(w_decl);
        end else begin
            w_n = w_avail;
        end
        w_plen = w_has ? w_decl : 8'd0;
    end

    always_comb begin
        n_state    = r_state;
        w_load_hdr = 1'b0;
        w_load_pay = 1'b0;
        w_rd_en    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc && i_frame_end) begin
                    n_state = ST_HDR;
                end
            end
            ST_HDR: begin
                if (w_out_free) begin
                    w_load_hdr = 1'b1;
                    n_state    = (w_n == CW'(0)) ? ST_IDLE : ST_PAY_RD;
                end
            end
            ST_PAY_RD: begin
                w_rd_en = 1'b1;
                n_state = ST_PAY_WR;
            end
            ST_PAY_WR: begin
                if (w_out_free) begin
                    w_load_pay = 1'b1;
                    n_state    = w_idx_last ? ST_IDLE : ST_PAY_RD;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= CW'(0);
            r_ovf     <= 1'b0;
            r_crc     <= CRC_INIT;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_store) begin
                r_count <= CW'(r_count + CW'(1));
                if (r_count >= CW'(2)) begin
                    r_crc <= crc_fold(r_crc, r_prev2);
                end
            end else if (w_in_acc) begin
                r_ovf <= 1'b1;
            end
            // Start the next frame once the header is out.
            if (w_load_hdr) begin
                r_count <= CW'(0);
                r_ovf   <= 1'b0;
                r_crc   <= CRC_INIT;
            end
            if (w_load_hdr || w_load_pay) begin
                r_o_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_store) begin
            r_mem[r_count[AW-1:0]] <= i_rx_byte;
            r_prev2 <= r_prev1;
            r_prev1 <= i_rx_byte;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < HDR_BYTES; k++) begin
            if (w_store && (r_count == CW'(k))) begin
                r_hb[k] <= i_rx_byte;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_hdr) begin
            r_n        <= w_n;
            r_pstart   <= w_pstart;
            r_idx      <= CW'(0);
            r_o_kind   <= 1'b0;
            r_o_err    <= w_err;
            r_o_unit   <= w_unit;
            r_o_func   <= w_func;
            r_o_start  <= w_start;
            r_o_qty    <= w_qty;
            r_o_cnt    <= w_cnt;
            r_o_plen   <= w_plen;
            r_o_rcrc   <= w_rcrc;
            r_o_ccrc   <= w_ccrc;
            r_o_pbyte  <= 8'd0;
            r_o_last   <= (w_n == CW'(0));
        end else if (w_load_pay) begin
            r_idx      <= CW'(r_idx + CW'(1));
            r_o_kind   <= 1'b1;
            r_o_err    <= ERR_OK;
            r_o_unit   <= 8'd0;
            r_o_func   <= 8'd0;
            r_o_start  <= 16'd0;
            r_o_qty    <= 16'd0;
            r_o_cnt    <= 8'd0;
            r_o_plen   <= 8'd0;
            r_o_rcrc   <= 16'd0;
            r_o_ccrc   <= 16'd0;
            r_o_pbyte  <= r_rd_data;
            r_o_last   <= w_idx_last;
        end
    end

    assign o_out_valid    = r_o_valid;
    assign o_kind         = r_o_kind;
    assign o_error_code   = r_o_err;
    assign o_unit_id      = r_o_unit;
    assign o_func_code    = r_o_func;
    assign o_start_addr   = r_o_start;
    assign o_quantity     = r_o_qty;
    assign o_count_byte   = r_o_cnt;
    assign o_payload_len  = r_o_plen;
    assign o_received_crc = r_o_rcrc;
    assign o_computed_crc = r_o_ccrc;
    assign o_payload_byte = r_o_pbyte;
    assign o_last         = r_o_last;

    `MRFD_ASSERT_NOW(a_pay_ok, o_out_valid && o_kind, o_error_code == ERR_OK, "payload error")
    `MRFD_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CW'(FRAME_BYTES), "count past buffer")
    `MRFD_ASSERT_NEXT(a_end_hdr, w_in_acc && i_frame_end, r_state == ST_HDR, "no header")
    `MRFD_ASSERT_NOW(a_idx_bound, r_state == ST_PAY_WR, r_idx < r_n, "index past count")

endmodule

`default_nettype wire

// ===== verif/mbrtu_frame_checker.sv =====
// Frame decoder checker: watches both channels, predicts decoded words, compares them.
`timescale 1ns / 100ps

package mbrtu_tb_pkg;
    import mbrtu_pkg::*;

    // Fold one byte into a reflected CRC-16 accumulator.
    function automatic logic [15:0] crc16_fold(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] c;
        c = acc ^ {8'h00, b};
        repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        return c;
    endfunction
endpackage

module mbrtu_frame_checker #(
    parameter int FRAME_BYTES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_frame_end,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic        i_kind,
    input  logic [2:0]  i_error_code,
    input  logic [7:0]  i_unit_id,
    input  logic [7:0]  i_func_code,
    input  logic [15:0] i_start_addr,
    input  logic [15:0] i_quantity,
    input  logic [7:0]  i_count_byte,
    input  logic [7:0]  i_payload_len,
    input  logic [15:0] i_received_crc,
    input  logic [15:0] i_computed_crc,
    input  logic [7:0]  i_payload_byte,
    input  logic        i_last,
    output int          o_fail_count,
    output int          o_pending
);
    import mbrtu_pkg::*;
    import mbrtu_tb_pkg::*;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic        kind;
        logic [2:0]  err;
        logic [7:0]  unit_id;
        logic [7:0]  fc;
        logic [15:0] addr;
        logic [15:0] qty;
        logic [7:0]  cnt;
        logic [7:0]  plen;
        logic [15:0] rx_crc;
        logic [15:0] calc_crc;
        logic [7:0]  data;
        logic        last;
    } t_decoded_word;

    logic [7:0]    frame_buf [FRAME_BYTES];
    int unsigned   frame_len;
    bit            overflowed;
    logic [15:0]   crc_acc;
    t_decoded_word expected_words [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        frame_len    = 0;
        overflowed   = 1'b0;
        crc_acc      = CRC_INIT;
    end

    // Stored byte i, zero at or past the limit.
    function automatic logic [7:0] byte_at(input int unsigned i, input int unsigned lim);
        if (i >= lim || i >= FRAME_BYTES) return 8'h00;
        return frame_buf[i];
    endfunction

    function automatic bit is_read_fc(input logic [7:0] fc);
        return fc >= FC_READ_FIRST && fc <= FC_READ_LAST;
    endfunction

    function automatic string show(input t_decoded_word w);
        return $sformatf({"kind=%0d err=%0d unit=%h fc=%h addr=%h qty=%h cnt=%h plen=%h ",
                          "rcrc=%h ccrc=%h data=%h last=%0d"},
                         w.kind, w.err, w.unit_id, w.fc, w.addr, w.qty, w.cnt, w.plen,
                         w.rx_crc, w.calc_crc, w.data, w.last);
    endfunction

    // Absorb one received word; on frame end queue the header and payload words.
    task automatic decode_word(input logic [7:0] b, input logic fe);
        t_decoded_word hdr;
        t_decoded_word pay;
        int unsigned   len;
        int unsigned   dlen;
        int unsigned   pstart;
        int unsigned   declared;
        int unsigned   avail;
        int unsigned   n;
        bit            has_payload;

        if (frame_len < FRAME_BYTES) begin
            frame_buf[frame_len] = b;
            if (frame_len >= 2) crc_acc = crc16_fold(crc_acc, frame_buf[frame_len - 2]);
            frame_len++;
        end else begin
            overflowed = 1'b1;
        end
        if (!fe) return;

        len         = frame_len;
        hdr         = '0;
        n           = 0;
        pstart      = 0;
        declared    = 0;
        has_payload = 1'b0;
        hdr.unit_id = byte_at(0, len);
        hdr.fc      = byte_at(1, len);

        if (overflowed) begin
            hdr.err = ERR_TOO_LONG;
        end else if (len < MIN_FRAME_LEN) begin
            hdr.err = ERR_TOO_SHORT;
        end else begin
            dlen         = len - 2;
            hdr.rx_crc   = {byte_at(len - 1, len), byte_at(len - 2, len)};
            hdr.calc_crc = crc_acc;
            if (hdr.rx_crc != hdr.calc_crc) begin
                hdr.err = ERR_BAD_CRC;
            end else if (is_read_fc(hdr.fc)) begin
                if (len == REQ_FRAME_LEN) begin
                    hdr.addr = {byte_at(2, dlen), byte_at(3, dlen)};
                    hdr.qty  = {byte_at(4, dlen), byte_at(5, dlen)};
                end else begin
                    hdr.cnt     = byte_at(2, dlen);
                    declared    = hdr.cnt;
                    pstart      = PSTART_READ;
                    has_payload = 1'b1;
                end
            end else if (hdr.fc == FC_WRITE_COIL || hdr.fc == FC_WRITE_REG) begin
                hdr.addr    = {byte_at(2, dlen), byte_at(3, dlen)};
                declared    = SINGLE_LEN;
                pstart      = PSTART_SINGLE;
                has_payload = 1'b1;
            end else if (hdr.fc == FC_WRITE_COILS || hdr.fc == FC_WRITE_REGS) begin
                hdr.addr    = {byte_at(2, dlen), byte_at(3, dlen)};
                hdr.qty     = {byte_at(4, dlen), byte_at(5, dlen)};
                hdr.cnt     = byte_at(6, dlen);
                declared    = hdr.cnt;
                pstart      = PSTART_MULTI;
                has_payload = 1'b1;
            end else begin
                hdr.err = ERR_BAD_FUNC;
            end
            if (has_payload) begin
                // Clip the payload to the bytes ahead of the CRC.
                avail    = (dlen > pstart) ? dlen - pstart : 0;
                hdr.plen = declared;
                n        = (declared < avail) ? declared : avail;
            end
        end

        hdr.last = (n == 0);
        expected_words.push_back(hdr);
        for (int unsigned i = 0; i < n; i++) begin
            pay      = '0;
            pay.kind = 1'b1;
            pay.data = byte_at(pstart + i, len);
            pay.last = (i + 1 == n);
            expected_words.push_back(pay);
        end

        frame_len  = 0;
        overflowed = 1'b0;
        crc_acc    = CRC_INIT;
    endtask

    always @(posedge i_clk) begin
        t_decoded_word got;
        t_decoded_word want;
        if (!i_rst_n) begin
            frame_len  = 0;
            overflowed = 1'b0;
            crc_acc    = CRC_INIT;
            expected_words.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got.kind     = i_kind;
                got.err      = i_error_code;
                got.unit_id  = i_unit_id;
                got.fc       = i_func_code;
                got.addr     = i_start_addr;
                got.qty      = i_quantity;
                got.cnt      = i_count_byte;
                got.plen     = i_payload_len;
                got.rx_crc   = i_received_crc;
                got.calc_crc = i_computed_crc;
                got.data     = i_payload_byte;
                got.last     = i_last;
                if (expected_words.size() == 0) begin
                    if (o_fail_count < REPORT_LIMIT)
                        $display("%0t: unexpected word: %s", $realtime, show(got));
                    o_fail_count++;
                end else begin
                    want = expected_words.pop_front();
                    if (got !== want) begin
                        if (o_fail_count < REPORT_LIMIT)
                            $display("%0t: mismatch\n  expected %s\n  actual   %s",
                                     $realtime, show(want), show(got));
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) decode_word(i_rx_byte, i_frame_end);
        end
        o_pending = expected_words.size();
    end

endmodule

// ===== verif/tb.sv =====
// Testbench top for the Modbus RTU frame decoder: frame stimulus, watchdog and verdict.
`timescale 1ns / 100ps

module tb;
    import mbrtu_pkg::*;
    import mbrtu_tb_pkg::*;

    localparam int FRAME_BYTES    = 64;
    localparam int ITEM_TARGET    = 430;
    localparam int IDLE_PCT       = 14;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 20;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic [7:0]  i_rx_byte   = 8'h00;
    logic        i_frame_end = 1'b0;
    logic        i_out_stall = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic        o_kind;
    logic [2:0]  o_error_code;
    logic [7:0]  o_unit_id;
    logic [7:0]  o_func_code;
    logic [15:0] o_start_addr;
    logic [15:0] o_quantity;
    logic [7:0]  o_count_byte;
    logic [7:0]  o_payload_len;
    logic [15:0] o_received_crc;
    logic [15:0] o_computed_crc;
    logic [7:0]  o_payload_byte;
    logic        o_last;

    int         fail_count;
    int         pending;
    int         words_sent = 0;
    int         quiet_cycles = 0;
    bit         quiet = 1'b0;
    logic [7:0] frame_q [$];

    modbus_rtu_frame_decoder_unit #(.FRAME_BYTES(FRAME_BYTES)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_rx_byte(i_rx_byte), .i_frame_end(i_frame_end),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_kind(o_kind), .o_error_code(o_error_code),
        .o_unit_id(o_unit_id), .o_func_code(o_func_code),
        .o_start_addr(o_start_addr), .o_quantity(o_quantity),
        .o_count_byte(o_count_byte), .o_payload_len(o_payload_len),
        .o_received_crc(o_received_crc), .o_computed_crc(o_computed_crc),
        .o_payload_byte(o_payload_byte), .o_last(o_last)
    );

    mbrtu_frame_checker #(.FRAME_BYTES(FRAME_BYTES)) chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_stall(o_in_stall),
        .i_rx_byte(i_rx_byte), .i_frame_end(i_frame_end),
        .i_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .i_kind(o_kind), .i_error_code(o_error_code),
        .i_unit_id(o_unit_id), .i_func_code(o_func_code),
        .i_start_addr(o_start_addr), .i_quantity(o_quantity),
        .i_count_byte(o_count_byte), .i_payload_len(o_payload_len),
        .i_received_crc(o_received_crc), .i_computed_crc(o_computed_crc),
        .i_payload_byte(o_payload_byte), .i_last(o_last),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        i_out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
    end

    // End the run when neither channel moves a word for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [7:0] rnd_byte();
        return 8'($urandom_range(255));
    endfunction

    function automatic bit is_decoded_fc(input logic [7:0] fc);
        return (fc >= FC_READ_FIRST && fc <= FC_READ_LAST) || fc == FC_WRITE_COIL ||
               fc == FC_WRITE_REG || fc == FC_WRITE_COILS || fc == FC_WRITE_REGS;
    endfunction

    // Mostly short payloads, now and then a large one.
    function automatic int payload_size(input int max_n);
        return ($urandom_range(9) == 0) ? $urandom_range(max_n) : $urandom_range(12);
    endfunction

    // Append the CRC, low byte first.
    task automatic seal_frame();
        logic [15:0] crc;
        crc = CRC_INIT;
        foreach (frame_q[i]) crc = crc16_fold(crc, frame_q[i]);
        frame_q.push_back(crc[7:0]);
        frame_q.push_back(crc[15:8]);
    endtask

    // Call at a falling edge; returns at the falling edge after acceptance.
    task automatic send_word(input logic [7:0] b, input logic fe);
        while (!quiet && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_rx_byte   <= b;
        i_frame_end <= fe;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
        words_sent++;
    endtask

    task automatic send_frame();
        foreach (frame_q[i]) send_word(frame_q[i], i == frame_q.size() - 1);
        frame_q.delete();
    endtask

    task automatic make_random_frame();
        int          pick;
        int          n;
        int          pos;
        logic [7:0]  fc;
        pick = $urandom_range(99);
        frame_q.push_back(rnd_byte());
        if (pick < 20) begin
            // read request
            frame_q.push_back(8'($urandom_range(FC_READ_LAST, FC_READ_FIRST)));
            repeat (4) frame_q.push_back(rnd_byte());
            seal_frame();
        end else if (pick < 38) begin
            // read response, count byte sometimes disagrees with the data
            n = payload_size(59);
            frame_q.push_back(8'($urandom_range(FC_READ_LAST, FC_READ_FIRST)));
            frame_q.push_back(($urandom_range(4) == 0) ? rnd_byte() : 8'(n));
            repeat (n) frame_q.push_back(rnd_byte());
            seal_frame();
        end else if (pick < 52) begin
            frame_q.push_back($urandom_range(1) ? FC_WRITE_REG : FC_WRITE_COIL);
            repeat (($urandom_range(4) == 0) ? $urandom_range(6) : 4)
                frame_q.push_back(rnd_byte());
            seal_frame();
        end else if (pick < 70) begin
            n = payload_size(55);
            frame_q.push_back($urandom_range(1) ? FC_WRITE_REGS : FC_WRITE_COILS);
            repeat (4) frame_q.push_back(rnd_byte());
            frame_q.push_back(($urandom_range(4) == 0) ? rnd_byte() : 8'(n));
            repeat (n) frame_q.push_back(rnd_byte());
            seal_frame();
        end else if (pick < 79) begin
            // corrupt one bit of an otherwise good frame
            case ($urandom_range(3))
                0: fc = FC_WRITE_COIL;
                1: fc = FC_WRITE_REGS;
                default: fc = 8'($urandom_range(FC_READ_LAST, FC_READ_FIRST));
            endcase
            frame_q.push_back(fc);
            repeat ($urandom_range(10, 4)) frame_q.push_back(rnd_byte());
            seal_frame();
            pos = $urandom_range(frame_q.size() - 1);
            frame_q[pos] = frame_q[pos] ^ (8'h01 << $urandom_range(7));
        end else if (pick < 86) begin
            // unknown function or exception reply
            if ($urandom_range(1)) begin
                do fc = rnd_byte(); while (is_decoded_fc(fc));
            end else begin
                fc = 8'($urandom_range(FC_READ_LAST, FC_READ_FIRST)) | 8'h80;
            end
            frame_q.push_back(fc);
            repeat ($urandom_range(6, 1)) frame_q.push_back(rnd_byte());
            seal_frame();
        end else if (pick < 92) begin
            repeat ($urandom_range(3)) frame_q.push_back(rnd_byte());
        end else if (pick < 95) begin
            repeat ($urandom_range(FRAME_BYTES + 6, FRAME_BYTES)) frame_q.push_back(rnd_byte());
        end else begin
            repeat ($urandom_range(19)) frame_q.push_back(rnd_byte());
            if ($urandom_range(1)) seal_frame();
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // single byte, too short
        frame_q = '{8'hFF};
        send_frame();
        // four bytes, still too short
        frame_q = '{8'h00, 8'hFF, 8'h00, 8'hFF};
        send_frame();
        // read request with extreme address and quantity
        frame_q = '{8'hFF, FC_READ_LAST, 8'hFF, 8'hFF, 8'h00, 8'h00};
        seal_frame();
        send_frame();
        // exception reply
        frame_q = '{8'h01, 8'h83, 8'h02};
        seal_frame();
        send_frame();
        // read response with an empty payload
        frame_q = '{8'h00, FC_READ_FIRST, 8'h00};
        seal_frame();
        send_frame();

        while (words_sent < ITEM_TARGET) begin
            quiet = (words_sent >= 150 && words_sent < 250);
            make_random_frame();
            send_frame();
        end
        quiet = 1'b0;
        i_in_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
